// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each use expands to one labeled
// concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ----- sv/tdc_pkg.sv -----
package tdc_pkg;

  // Width of the grasp and hold counters.
  localparam int TICK_BITS = 16;
  // Width of the two tick thresholds in the register file.
  localparam int CFG_TICK_BITS = 16;
  localparam int LEVEL_BITS = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  // Common width for counter/threshold compares.
  localparam int CMP_W = (TICK_BITS > CFG_TICK_BITS) ? TICK_BITS : CFG_TICK_BITS;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [CFG_TICK_BITS-1:0] cfg_tick_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [CMP_W-1:0] cmp_t;

  localparam tick_t TICK_MAX = {TICK_BITS{1'b1}};

  // Register reset values.
  localparam cfg_tick_t SHORT_PRESS_RESET = CFG_TICK_BITS'(50);
  localparam cfg_tick_t HOLD_STEP_RESET = CFG_TICK_BITS'(1000);
  localparam level_t TOP_LEVEL_RESET = LEVEL_BITS'(10);

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_PRESS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_STEP = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOP_LEVEL = 2'd2;

  typedef enum logic [2:0] {
    OP_GRASP       = 3'd0,
    OP_RELEASE     = 3'd1,
    OP_TICK        = 3'd2,
    OP_RESET       = 3'd3,
    OP_WRITE_LEVEL = 3'd4,
    OP_WRITE_SAVED = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_INC_ON  = 2'd0,
    MODE_INC_OFF = 2'd1,
    MODE_DEC_ON  = 2'd2,
    MODE_DEC_OFF = 2'd3
  } mode_t;

  typedef struct packed {
    cfg_tick_t short_press_ticks;
    cfg_tick_t hold_step_ticks;
    level_t    top_level;
  } cfg_t;

  typedef struct packed {
    logic   grasped;
    tick_t  grasp_ticks;
    tick_t  hold_ticks;
    level_t level_now;
    level_t level_saved;
    mode_t  mode;
  } state_t;

  typedef struct packed {
    logic touch;
    logic hold;
  } flags_t;

endpackage

// ----- sv/tdc_step.sv -----
// Next-state logic for one item: button counters, toggle, ramp step, reset and level writes.
module tdc_step (
  input  tdc_pkg::state_t       cur,
  input  tdc_pkg::cfg_t         cfg,
  input  logic [2:0]            op,
  input  tdc_pkg::level_t       value,
  output tdc_pkg::state_t       nxt,
  output tdc_pkg::flags_t       flags
);

  function automatic tdc_pkg::tick_t sat_inc(input tdc_pkg::tick_t v);
    sat_inc = (v == tdc_pkg::TICK_MAX) ? v : v + 1'b1;
  endfunction

  tdc_pkg::tick_t   grasp_inc;
  tdc_pkg::tick_t   hold_inc;
  logic             press_ok;
  logic             step_due;
  logic [4:0]       level_up;
  tdc_pkg::state_t  toggled;
  tdc_pkg::state_t  stepped;

  assign grasp_inc = sat_inc(cur.grasp_ticks);
  assign hold_inc  = sat_inc(cur.hold_ticks);
  assign step_due  = tdc_pkg::cmp_t'(hold_inc) > tdc_pkg::cmp_t'(cfg.hold_step_ticks);
  assign press_ok  = (tdc_pkg::cmp_t'(cur.grasp_ticks) > tdc_pkg::cmp_t'(cfg.short_press_ticks))
                  && (tdc_pkg::cmp_t'(cur.grasp_ticks) < tdc_pkg::cmp_t'(cfg.hold_step_ticks));
  assign level_up  = {1'b0, cur.level_now} + 5'd1;

  // On/off toggle: on saves and goes dark, off restores the saved level.
  always_comb begin
    toggled = cur;
    case (cur.mode)
      tdc_pkg::MODE_INC_ON: begin
        toggled.level_saved = cur.level_now;
        toggled.level_now   = '0;
        toggled.mode        = tdc_pkg::MODE_INC_OFF;
      end
      tdc_pkg::MODE_DEC_ON: begin
        toggled.level_saved = cur.level_now;
        toggled.level_now   = '0;
        toggled.mode        = tdc_pkg::MODE_DEC_OFF;
      end
      tdc_pkg::MODE_INC_OFF: begin
        toggled.level_now = cur.level_saved;
        toggled.mode      = tdc_pkg::MODE_INC_ON;
      end
      default: begin
        toggled.level_now = cur.level_saved;
        toggled.mode      = tdc_pkg::MODE_DEC_ON;
      end
    endcase
  end

  // Ramp step: up to top_level, then down to zero, clamped at both ends.
  always_comb begin
    stepped = cur;
    if (cur.mode inside {tdc_pkg::MODE_INC_ON, tdc_pkg::MODE_INC_OFF}) begin
      if (level_up >= {1'b0, cfg.top_level}) begin
        stepped.level_now = cfg.top_level;
        stepped.mode      = tdc_pkg::MODE_DEC_ON;
      end else begin
        stepped.level_now = level_up[3:0];
        if (cur.mode == tdc_pkg::MODE_INC_OFF) stepped.mode = tdc_pkg::MODE_DEC_ON;
      end
    end else begin
      if (cur.level_now <= 4'd1) begin
        stepped.level_now = '0;
        stepped.mode      = tdc_pkg::MODE_INC_ON;
      end else begin
        stepped.level_now = cur.level_now - 4'd1;
        if (cur.mode == tdc_pkg::MODE_DEC_OFF) stepped.mode = tdc_pkg::MODE_INC_ON;
      end
    end
  end

  always_comb begin
    nxt         = cur;
    flags.touch = 1'b0;
    flags.hold  = 1'b0;
    case (op)
      tdc_pkg::OP_GRASP: begin
        if (!cur.grasped) begin
          nxt.grasp_ticks = '0;
          nxt.hold_ticks  = '0;
          nxt.grasped     = 1'b1;
        end
      end
      tdc_pkg::OP_RELEASE: begin
        if (cur.grasped) begin
          if (press_ok) begin
            nxt         = toggled;
            flags.touch = 1'b1;
          end
          nxt.grasp_ticks = '0;
          nxt.hold_ticks  = '0;
          nxt.grasped     = 1'b0;
        end
      end
      tdc_pkg::OP_TICK: begin
        if (cur.grasped) begin
          if (step_due) begin
            nxt            = stepped;
            flags.hold     = 1'b1;
            nxt.hold_ticks = '0;
          end else begin
            nxt.hold_ticks = hold_inc;
          end
          nxt.grasp_ticks = grasp_inc;
        end
      end
      tdc_pkg::OP_RESET: begin
        nxt.grasp_ticks = '0;
        nxt.grasped     = 1'b0;
        nxt.level_now   = '0;
        nxt.level_saved = '0;
        nxt.mode        = tdc_pkg::MODE_INC_OFF;
      end
      tdc_pkg::OP_WRITE_LEVEL: begin
        nxt.level_now = (value > cfg.top_level) ? cfg.top_level : value;
      end
      tdc_pkg::OP_WRITE_SAVED: begin
        nxt.level_saved = (value > cfg.top_level) ? cfg.top_level : value;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/touch_dimmer_controller.sv -----
// Single-button touch dimmer. Each input item (grasp, release, millisecond
// tick, reset, level write, saved-level write) passes once through the
// step logic and yields exactly one result item carrying the level, the
// saved level, the ramp mode, the grasp flag and the two event flags. The
// block takes one item per clock cycle while in_stall is low: the only
// register between input and output is the result register, and
// in_stall rises only while a result waits under out_stall.
// Configuration writes (cfg_index 0 short press ticks, 1 hold step ticks,
// 2 top level, 3 ignored) are always ready and take effect next cycle.
`include "assert_macros.svh"

module touch_dimmer_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  // item input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            op,
  input  tdc_pkg::level_t                       value,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tdc_pkg::level_t                       level,
  output tdc_pkg::level_t                       saved_level,
  output logic [1:0]                            dimmer_mode,
  output logic                                  is_grasped,
  output logic                                  touch_fired,
  output logic                                  hold_fired,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tdc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [tdc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  tdc_pkg::cfg_t   cfg;
  tdc_pkg::state_t state;
  tdc_pkg::state_t state_next;
  tdc_pkg::flags_t flags;
  logic            in_take;

  // Result register frees up when empty or being drained this cycle.
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_press_ticks <= tdc_pkg::SHORT_PRESS_RESET;
      cfg.hold_step_ticks   <= tdc_pkg::HOLD_STEP_RESET;
      cfg.top_level         <= tdc_pkg::TOP_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tdc_pkg::CFG_SHORT_PRESS: cfg.short_press_ticks <= cfg_data;
        tdc_pkg::CFG_HOLD_STEP:   cfg.hold_step_ticks   <= cfg_data;
        tdc_pkg::CFG_TOP_LEVEL:   cfg.top_level         <= cfg_data[tdc_pkg::LEVEL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  tdc_step u_step (
    .cur   (state),
    .cfg   (cfg),
    .op    (op),
    .value (value),
    .nxt   (state_next),
    .flags (flags)
  );

  // Dimmer state advances on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.grasped     <= 1'b0;
      state.grasp_ticks <= '0;
      state.hold_ticks  <= '0;
      state.level_now   <= '0;
      state.level_saved <= '0;
      state.mode        <= tdc_pkg::MODE_INC_OFF;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Result register: valid is control, payload loads with the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      level       <= state_next.level_now;
      saved_level <= state_next.level_saved;
      dimmer_mode <= state_next.mode;
      is_grasped  <= state_next.grasped;
      touch_fired <= flags.touch;
      hold_fired  <= flags.hold;
    end
  end

  // A toggle and a ramp step come from different ops.
  `ASSERT_CLK(a_one_event, out_valid |-> !(touch_fired && hold_fired))
  // A toggle always ends the press; a ramp step happens only while held.
  `ASSERT_CLK(a_touch_released, (out_valid && touch_fired) |-> !is_grasped)
  `ASSERT_CLK(a_hold_grasped, (out_valid && hold_fired) |-> is_grasped)
  // Input backs up only behind a held result.
  `ASSERT_CLK_ALWAYS(a_stall_cause, in_stall |-> out_valid)

endmodule
